FILE: design/mcpbm_pkg.sv
package mcpbm_pkg;

   // Bus access kinds carried on the mode field.
   localparam logic [1:0] MODE_CPU_READ  = 2'd0;
   localparam logic [1:0] MODE_CPU_WRITE = 2'd1;
   localparam logic [1:0] MODE_PPU_READ  = 2'd2;
   localparam logic [1:0] MODE_PPU_WRITE = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_PRG_BANK_COUNT = 1'b0;
   localparam logic CSR_CHR_IS_RAM     = 1'b1;

   // Field widths.
   localparam int ADDR_W   = 16;
   localparam int MAPPED_W = 20;
   localparam int COUNT_W  = 7;
   localparam int CMD_W    = 9;
   localparam int INNER_W  = 3;
   localparam int DVD_W    = 6;
   localparam int OFFS_W   = 14;
   localparam int CHR_W    = 13;

   // Default bank limit.
   localparam int MAX_PRG_BANKS_DEF = 64;

   // Inner bank masks for the 32KB-style sub-mode.
   localparam logic [DVD_W-1:0] PAIR_MASK = 6'h06;
   localparam logic [DVD_W-1:0] ODD_BIT   = 6'h01;
   localparam logic [DVD_W-1:0] LAST_BANK = 6'h07;

   // Request to the remainder unit.
   typedef struct packed {
      logic               start;
      logic [DVD_W-1:0]   dividend;
      logic [COUNT_W-1:0] divisor;
   } mod_req_type;

   // Answer from the remainder unit.
   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] remainder;
   } mod_rsp_type;

endpackage

FILE: design/mcpbm_mod_unit.sv
module mcpbm_mod_unit (
   input  logic                clock,
   input  logic                reset,
   input  mcpbm_pkg::mod_req_type req,
   output mcpbm_pkg::mod_rsp_type rsp
);

   localparam int StepW = $clog2(mcpbm_pkg::DVD_W + 1);
   localparam logic [StepW-1:0] Steps = StepW'(mcpbm_pkg::DVD_W);

   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   logic [StepW-1:0]               cnt_ff, cnt_in;
   logic [mcpbm_pkg::DVD_W-1:0]    dvd_ff, dvd_in;
   logic [mcpbm_pkg::DVD_W-1:0]    rem_ff, rem_in;
   logic [mcpbm_pkg::COUNT_W-1:0]  div_ff, div_in;
   logic [mcpbm_pkg::DVD_W:0]      shifted;
   logic [mcpbm_pkg::DVD_W+1:0]    diff;

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   assign shifted = {rem_ff, dvd_ff[mcpbm_pkg::DVD_W-1]};
   assign diff    = {1'b0, shifted} - {1'b0, div_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (req.start) begin
         run_in = 1'b1;
         cnt_in = Steps;
         dvd_in = req.dividend;
         rem_in = '0;
         div_in = req.divisor;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[mcpbm_pkg::DVD_W-2:0], 1'b0};
         if (!diff[mcpbm_pkg::DVD_W+1]) begin
            rem_in = diff[mcpbm_pkg::DVD_W-1:0];
         end else begin
            rem_in = shifted[mcpbm_pkg::DVD_W-1:0];
         end
         cnt_in = cnt_ff - StepW'(1);
         if (cnt_ff == StepW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

FILE: design/multicart_prg_bank_mapper_core.sv
// Channel     | Ports                                     | Transfer
// ------------+-------------------------------------------+------------------------------
// request     | start, busy, req_mode, req_address        | edge with start high, busy low
// response    | rsp_strobe, rsp_hit, rsp_mapped_address,  | every cycle rsp_strobe is high
//             | rsp_mirror_horizontal                     |
// config      | csr_write_enable, csr_index,              | edge with csr_write_enable high
//             | csr_write_data                            |
//
// Every access gives its response in the cycle after the transfer.
// Reads, PPU accesses and CPU writes below 8000 keep busy high for one cycle.
// A CPU write at 8000-FFFF, or a write of the bank count, recomputes both window
// banks on one 6-step remainder unit used twice, low window first; busy stays high
// until both are done, or for one cycle when the effective bank count is zero.
// Reset is synchronous; it restores the register defaults and clears the latches.
// The response side has no stall; a response is valid for exactly one cycle.
module multicart_prg_bank_mapper_core #(
   parameter int MAX_PRG_BANKS = mcpbm_pkg::MAX_PRG_BANKS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_mode,
   input  logic [mcpbm_pkg::ADDR_W-1:0]        req_address,
   output logic                                rsp_strobe,
   output logic                                rsp_hit,
   output logic [mcpbm_pkg::MAPPED_W-1:0]      rsp_mapped_address,
   output logic                                rsp_mirror_horizontal,
   input  logic                                csr_write_enable,
   input  logic                                csr_index,
   input  logic [mcpbm_pkg::COUNT_W-1:0]       csr_write_data
);

   localparam int BankW = (MAX_PRG_BANKS > 1) ? $clog2(MAX_PRG_BANKS) : 1;
   localparam logic [mcpbm_pkg::COUNT_W-1:0] MaxCount = mcpbm_pkg::COUNT_W'(MAX_PRG_BANKS);
   localparam logic [mcpbm_pkg::COUNT_W-1:0] ResetCount = mcpbm_pkg::COUNT_W'(8);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_RESP = 5'b00010,
      ST_PREP = 5'b00100,
      ST_LO   = 5'b01000,
      ST_HI   = 5'b10000
   } state_type;

   state_type                          state_ff, state_in;
   logic [mcpbm_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                               chr_ram_ff, chr_ram_in;
   logic [mcpbm_pkg::CMD_W-1:0]        cmd_ff, cmd_in;
   logic [mcpbm_pkg::INNER_W-1:0]      inner_ff, inner_in;
   logic [BankW-1:0]                   low_win_ff, low_win_in;
   logic [BankW-1:0]                   high_win_ff, high_win_in;
   logic                               strobe_ff, strobe_in;
   logic                               hit_ff, hit_in;
   logic [mcpbm_pkg::MAPPED_W-1:0]     mapped_ff, mapped_in;
   logic                               mirror_ff, mirror_in;

   logic                               accept;
   logic                               latch_write;
   logic                               count_write;
   logic [mcpbm_pkg::COUNT_W-1:0]      count_eff;
   logic [mcpbm_pkg::DVD_W-1:0]        base;
   logic [mcpbm_pkg::DVD_W-1:0]        inner6;
   logic [mcpbm_pkg::DVD_W-1:0]        lo_val;
   logic [mcpbm_pkg::DVD_W-1:0]        hi_val;
   logic [mcpbm_pkg::DVD_W-1:0]        sel_win;
   mcpbm_pkg::mod_req_type             mod_req;
   mcpbm_pkg::mod_rsp_type             mod_rsp;

   assign accept      = start && !busy;
   assign busy        = (state_ff != ST_IDLE);
   assign latch_write = accept && (req_mode == mcpbm_pkg::MODE_CPU_WRITE) && req_address[15];
   assign count_write = csr_write_enable && (csr_index == mcpbm_pkg::CSR_PRG_BANK_COUNT);

   // Bank count above the limit acts as the limit.
   assign count_eff = (count_ff > MaxCount) ? MaxCount : count_ff;

   // Window bank operands before reduction.
   assign base   = cmd_ff[7:2];
   assign inner6 = mcpbm_pkg::DVD_W'(inner_ff);
   always_comb begin
      if (cmd_ff[1]) begin
         if (cmd_ff[8]) begin
            lo_val = base | inner6;
            hi_val = base | mcpbm_pkg::LAST_BANK;
         end else begin
            lo_val = base | (inner6 & mcpbm_pkg::PAIR_MASK);
            hi_val = base | (inner6 & mcpbm_pkg::PAIR_MASK) | mcpbm_pkg::ODD_BIT;
         end
      end else begin
         lo_val = base | inner6;
         hi_val = base | inner6;
      end
   end

   // Requests to the shared remainder unit: low window first, then high window.
   always_comb begin
      mod_req.start    = 1'b0;
      mod_req.dividend = lo_val;
      mod_req.divisor  = count_eff;
      if ((state_ff == ST_PREP) && (count_eff != '0)) begin
         mod_req.start = 1'b1;
      end else if ((state_ff == ST_LO) && mod_rsp.done) begin
         mod_req.start    = 1'b1;
         mod_req.dividend = hi_val;
      end
   end

   mcpbm_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

   // Configuration registers and the command and bank latches.
   always_comb begin
      count_in   = count_ff;
      chr_ram_in = chr_ram_ff;
      cmd_in     = cmd_ff;
      inner_in   = inner_ff;
      if (csr_write_enable) begin
         case (csr_index)
            mcpbm_pkg::CSR_PRG_BANK_COUNT: count_in   = csr_write_data;
            default:                       chr_ram_in = csr_write_data[0];
         endcase
      end
      if (latch_write) begin
         if (req_address[14]) begin
            inner_in = req_address[mcpbm_pkg::INNER_W-1:0];
         end else begin
            cmd_in = req_address[mcpbm_pkg::CMD_W-1:0];
         end
      end
   end

   // Response for the accepted access.
   assign sel_win = req_address[14] ? mcpbm_pkg::DVD_W'(high_win_ff)
                                    : mcpbm_pkg::DVD_W'(low_win_ff);
   always_comb begin
      strobe_in = accept;
      hit_in    = hit_ff;
      mapped_in = mapped_ff;
      mirror_in = mirror_ff;
      if (accept) begin
         hit_in    = 1'b0;
         mapped_in = '0;
         mirror_in = cmd_in[0];
         case (req_mode)
            mcpbm_pkg::MODE_CPU_READ: begin
               if (req_address[15]) begin
                  hit_in    = 1'b1;
                  mapped_in = {sel_win, req_address[mcpbm_pkg::OFFS_W-1:0]};
               end
            end
            mcpbm_pkg::MODE_PPU_READ: begin
               if (req_address[15:13] == 3'b000) begin
                  hit_in    = 1'b1;
                  mapped_in = mcpbm_pkg::MAPPED_W'(req_address[mcpbm_pkg::CHR_W-1:0]);
               end
            end
            mcpbm_pkg::MODE_PPU_WRITE: begin
               if (req_address[15:13] == 3'b000) begin
                  hit_in    = chr_ram_ff;
                  mapped_in = mcpbm_pkg::MAPPED_W'(req_address[mcpbm_pkg::CHR_W-1:0]);
               end
            end
            default: begin
               hit_in = 1'b0;
            end
         endcase
      end
   end

   // Sequencer for the window bank recompute.
   always_comb begin
      state_in    = state_ff;
      low_win_in  = low_win_ff;
      high_win_in = high_win_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = latch_write ? ST_PREP : ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         ST_PREP: begin
            if (count_eff == '0) begin
               low_win_in  = '0;
               high_win_in = '0;
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_LO;
            end
         end
         ST_LO: begin
            if (mod_rsp.done) begin
               low_win_in = mod_rsp.remainder[BankW-1:0];
               state_in   = ST_HI;
            end
         end
         ST_HI: begin
            if (mod_rsp.done) begin
               high_win_in = mod_rsp.remainder[BankW-1:0];
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // A new bank count restarts the recompute from the top.
      if (count_write) begin
         state_in = ST_PREP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= ResetCount;
         chr_ram_ff  <= 1'b1;
         cmd_ff      <= '0;
         inner_ff    <= '0;
         low_win_ff  <= '0;
         high_win_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         chr_ram_ff  <= chr_ram_in;
         cmd_ff      <= cmd_in;
         inner_ff    <= inner_in;
         low_win_ff  <= low_win_in;
         high_win_ff <= high_win_in;
         strobe_ff   <= strobe_in;
      end
      hit_ff    <= hit_in;
      mapped_ff <= mapped_in;
      mirror_ff <= mirror_in;
   end

   assign rsp_strobe            = strobe_ff;
   assign rsp_hit               = hit_ff;
   assign rsp_mapped_address    = mapped_ff;
   assign rsp_mirror_horizontal = mirror_ff;

   // Every transfer gives exactly one response, in the next cycle.
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("response missing after a request transfer");

   a_resp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept))
      else $error("response without a request transfer");

   // Once settled, both window banks lie below the bank count.
   a_windows_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && (count_eff != '0) |->
         (mcpbm_pkg::COUNT_W'(low_win_ff) < count_eff) &&
         (mcpbm_pkg::COUNT_W'(high_win_ff) < count_eff))
      else $error("window bank not reduced below the bank count");

   a_windows_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && (count_eff == '0) |->
         (low_win_ff == '0) && (high_win_ff == '0))
      else $error("window bank not zero with a bank count of zero");

endmodule
